/* rtl/core/salc_pkg.sv */
// shared types and constants of the set-associative lru tag unit
// no dependencies
`default_nettype none

package salc_pkg;

  localparam int WAYS_DEFAULT       = 4;
  localparam int SETS_DEFAULT       = 64;
  localparam int ADDR_WIDTH_DEFAULT = 32;

  localparam int ADDR_W     = 32;
  localparam int BLK_W      = 32;
  localparam int STAMP_W    = 64;
  localparam int CNT_W      = 32;
  localparam int OFFSET_W   = 4;
  localparam int SET_BITS_W = 3;
  localparam int SET_RAW_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [OFFSET_W-1:0]   OFFSET_RESET   = 4'd6;
  localparam logic [SET_BITS_W-1:0] SET_BITS_RESET = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX    = 2'd1;

  typedef struct packed {
    logic               valid;
    logic [BLK_W-1:0]   blk;
    logic [STAMP_W-1:0] stamp;
  } line_t;

endpackage

`default_nettype wire

/* rtl/core/salc_tag_ram.sv */
// tag ram: one row of lines per set, registered read
// depends on salc_pkg
`default_nettype none

module salc_tag_ram
  import salc_pkg::*;
#(
  parameter int WAYS  = WAYS_DEFAULT,
  parameter int SETS  = SETS_DEFAULT,
  parameter int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire logic [SET_W-1:0]      rd_addr,
  output line_t     [WAYS-1:0]       rd_data,
  input  wire logic                  wr_en,
  input  wire logic [SET_W-1:0]      wr_addr,
  input  wire line_t [WAYS-1:0]      wr_data
);

  line_t [WAYS-1:0] mem [SETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/salc_way_select.sv */
// hit detection and victim choice over one set row
// depends on salc_pkg
`default_nettype none

module salc_way_select
  import salc_pkg::*;
#(
  parameter int WAYS  = WAYS_DEFAULT,
  parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  wire line_t [WAYS-1:0] row,
  input  wire logic [BLK_W-1:0] blk,
  output logic                  hit,
  output logic      [WAY_W-1:0] way
);

  logic [WAYS-1:0]  hit_vec;
  logic [WAYS-1:0]  inv_vec;
  logic [WAYS-1:0]  oldest;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] lru_way;

  // one level of pairwise compares, first minimal stamp wins
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = row[i].valid && (row[i].blk == blk);
      inv_vec[i] = !row[i].valid;
      oldest[i]  = 1'b1;
      for (int j = 0; j < WAYS; j++) begin
        if ((j < i) && !(row[i].stamp < row[j].stamp)) begin
          oldest[i] = 1'b0;
        end
        if ((j > i) && !(row[i].stamp <= row[j].stamp)) begin
          oldest[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (inv_vec[w]) begin
        inv_way = WAY_W'(w);
      end
      if (oldest[w]) begin
        lru_way = WAY_W'(w);
      end
    end
  end

  assign hit = |hit_vec;

  always_comb begin
    if (hit) begin
      way = hit_way;
    end else if (|inv_vec) begin
      way = inv_way;
    end else begin
      way = lru_way;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/set_assoc_lru_cache_tags_unit.sv */
// Tag store of a set-associative cache with lru replacement, counting hits and misses.
// An address is taken when start is high and busy is low; its result appears on the
// result ports after the tag ram read and the lookup state, with done high for exactly
// one cycle, and the receiver cannot stall it. The set row is read when the address is
// taken; in the lookup state the ways are compared, the victim picked and the row
// written back. busy stays high in the lookup state, so a following request to the same
// set always reads the updated row. After reset a clearing pass writes one set row per
// cycle for all SETS rows with busy high; configuration writes are taken at any time.
// depends on salc_pkg, salc_tag_ram, salc_way_select
`default_nettype none

module set_assoc_lru_cache_tags_unit
  import salc_pkg::*;
#(
  parameter int WAYS       = WAYS_DEFAULT,
  parameter int SETS       = SETS_DEFAULT,
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [ADDR_W-1:0]     address,
  output logic                       done,
  output logic                       hit,
  output logic      [1:0]            way_used,
  output logic      [CNT_W-1:0]      access_total,
  output logic      [CNT_W-1:0]      hit_total,
  output logic      [CNT_W-1:0]      miss_total,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_RAW_N = 1 << SET_RAW_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_WIDTH >= ADDR_W) ? {ADDR_W{1'b1}}
                                          : ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0]            state;
  logic [SET_W-1:0]      clr_set;
  logic [OFFSET_W-1:0]   block_offset_bits;
  logic [SET_BITS_W-1:0] set_index_bits;
  logic [STAMP_W-1:0]    time_now;
  logic [STAMP_W-1:0]    time_next;
  logic [CNT_W-1:0]      access_counter;
  logic [CNT_W-1:0]      hit_counter;
  logic [CNT_W-1:0]      miss_counter;
  logic [CNT_W-1:0]      access_next;
  logic [CNT_W-1:0]      hit_next;
  logic [CNT_W-1:0]      miss_next;

  logic                  accept;
  logic [BLK_W-1:0]      blk_in;
  logic [SET_RAW_W-1:0]  set_raw;
  logic [SET_W-1:0]      set_in;
  logic [SET_W-1:0]      set_map [SET_RAW_N];
  logic [BLK_W-1:0]      blk_q;
  logic [SET_W-1:0]      set_q;

  line_t [WAYS-1:0]      rd_row;
  line_t [WAYS-1:0]      wr_row;
  logic                  wr_en;
  logic [SET_W-1:0]      wr_addr;
  logic                  sel_hit;
  logic [WAY_W-1:0]      sel_way;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  for (genvar i = 0; i < SET_RAW_N; i++) begin : g_set_map
    assign set_map[i] = SET_W'(i % SETS);
  end

  assign blk_in  = (address & ADDR_MASK) >> block_offset_bits;
  assign set_raw = blk_in[SET_RAW_W-1:0]
                 & SET_RAW_W'((8'd1 << set_index_bits) - 8'd1);
  assign set_in  = set_map[set_raw];

  salc_tag_ram #(
    .WAYS  (WAYS),
    .SETS  (SETS),
    .SET_W (SET_W)
  ) u_tag_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (set_in),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row)
  );

  salc_way_select #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_way_select (
    .row (rd_row),
    .blk (blk_q),
    .hit (sel_hit),
    .way (sel_way)
  );

  assign time_next   = time_now + 64'd1;
  assign access_next = (access_counter == '1) ? access_counter : access_counter + 1'b1;
  assign hit_next    = (sel_hit && (hit_counter != '1)) ? hit_counter + 1'b1 : hit_counter;
  assign miss_next   = (!sel_hit && (miss_counter != '1)) ? miss_counter + 1'b1
                                                          : miss_counter;

  always_comb begin
    wr_row = rd_row;
    if (state == ST_CLEAR) begin
      wr_row = '0;
    end else if (sel_hit) begin
      wr_row[sel_way].stamp = time_next;
    end else begin
      wr_row[sel_way].valid = 1'b1;
      wr_row[sel_way].blk   = blk_q;
      wr_row[sel_way].stamp = time_next;
    end
  end

  assign wr_en   = (state == ST_CLEAR) || (state == ST_LOOKUP);
  assign wr_addr = (state == ST_CLEAR) ? clr_set : set_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_set        <= '0;
      time_now       <= '0;
      access_counter <= '0;
      hit_counter    <= '0;
      miss_counter   <= '0;
      done           <= 1'b0;
    end else begin
      done <= (state == ST_LOOKUP);
      unique case (state)
        ST_CLEAR: begin
          clr_set <= clr_set + 1'b1;
          if (clr_set == SET_W'(SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state          <= ST_IDLE;
          time_now       <= time_next;
          access_counter <= access_next;
          hit_counter    <= hit_next;
          miss_counter   <= miss_next;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_q <= blk_in;
      set_q <= set_in;
    end
    if (state == ST_LOOKUP) begin
      hit          <= sel_hit;
      way_used     <= 2'(sel_way);
      access_total <= access_next;
      hit_total    <= hit_next;
      miss_total   <= miss_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_offset_bits <= OFFSET_RESET;
      set_index_bits    <= SET_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLOCK_OFFSET: block_offset_bits <= cfg_data[OFFSET_W-1:0];
        CFG_SET_INDEX:    set_index_bits    <= cfg_data[SET_BITS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  a_done_after_lookup: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_LOOKUP)
    else $error("result strobe without a lookup cycle");

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_LOOKUP)
    else $error("accepted request did not enter lookup");

  a_lookup_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOKUP |=> state == ST_IDLE && done)
    else $error("lookup did not finish in one cycle");

  a_totals_add_up: assert property (@(posedge clk) disable iff (rst)
    done && (access_total != '1) |->
      {1'b0, access_total} == {1'b0, hit_total} + {1'b0, miss_total})
    else $error("hit and miss totals disagree with access total");

endmodule

`default_nettype wire
